// File: src/ibmw_pkg.sv
// ----------------------------------------------------------------------------
// Inode block map walker package
// Sizes, thresholds and status codes shared by the walker and its channels.
// ----------------------------------------------------------------------------
package ibmw_pkg;

   // Geometry of the block map.
   localparam int PTRS_PER_BLOCK = 128;
   localparam int DIRECT_SLOTS   = 12;
   localparam int NUM_SLOTS      = 15;
   localparam int SLOT_SINGLE    = 12;
   localparam int SLOT_DOUBLE    = 13;
   localparam int SLOT_TRIPLE    = 14;

   // Field widths of the channels.
   localparam int OP_W    = 2;
   localparam int SLOT_W  = 4;
   localparam int PTR_W   = 32;
   localparam int LBLK_W  = 22;
   localparam int INDEX_W = 7;
   localparam int LEVEL_W = 2;

   // Bits of one pointer index and of an offset within the indirect reach.
   localparam int PTR_BITS = $clog2(PTRS_PER_BLOCK);
   localparam int OFF_W    = (3 * PTR_BITS < LBLK_W) ? 3 * PTR_BITS : LBLK_W;

   // Number of blocks reached through each indirect level.
   localparam longint SPAN_1 = longint'(PTRS_PER_BLOCK);
   localparam longint SPAN_2 = SPAN_1 * SPAN_1;
   localparam longint SPAN_3 = SPAN_2 * SPAN_1;

   // First logical block past the direct, single, double and triple reach.
   localparam longint LIMIT_DIRECT = longint'(DIRECT_SLOTS);
   localparam longint LIMIT_SINGLE = LIMIT_DIRECT + SPAN_1;
   localparam longint LIMIT_DOUBLE = LIMIT_SINGLE + SPAN_2;
   localparam longint LIMIT_TRIPLE = LIMIT_DOUBLE + SPAN_3;

   // Operation codes of a request beat.
   localparam logic [OP_W-1:0] OP_LOAD      = 2'd0;
   localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd1;
   localparam logic [OP_W-1:0] OP_RESPONSE  = 2'd2;

   // Status codes of a response beat.
   typedef enum logic [1:0] {
      STATUS_READ   = 2'd0,
      STATUS_MAPPED = 2'd1,
      STATUS_HOLE   = 2'd2,
      STATUS_RANGE  = 2'd3
   } status_type;

endpackage

// File: src/ibmw_req_if.sv
// ----------------------------------------------------------------------------
// Inode block map walker request channel
// Valid/ready channel that carries load, translate and read response beats.
// ----------------------------------------------------------------------------
interface ibmw_req_if;
   logic                          valid;
   logic                          ready;
   logic [ibmw_pkg::OP_W-1:0]     op;
   logic [ibmw_pkg::SLOT_W-1:0]   slot;
   logic [ibmw_pkg::PTR_W-1:0]    pointer_value;
   logic [ibmw_pkg::LBLK_W-1:0]   logical_block;

   modport source (output valid, output op, output slot, output pointer_value,
                   output logical_block, input ready);
   modport sink   (input valid, input op, input slot, input pointer_value,
                   input logical_block, output ready);
endinterface

// File: src/ibmw_rsp_if.sv
// ----------------------------------------------------------------------------
// Inode block map walker response channel
// Valid/ready channel that carries read requests and walk results.
// ----------------------------------------------------------------------------
interface ibmw_rsp_if;
   logic                           valid;
   logic                           ready;
   ibmw_pkg::status_type           status;
   logic [ibmw_pkg::PTR_W-1:0]     block_addr;
   logic [ibmw_pkg::INDEX_W-1:0]   word_index;

   modport source (output valid, output status, output block_addr,
                   output word_index, input ready);
   modport sink   (input valid, input status, input block_addr,
                   input word_index, output ready);
endinterface

// File: src/inode_block_map_walker.sv
// ----------------------------------------------------------------------------
// Inode block map walker
// Translates file-relative block numbers through an inode's block map.
// ----------------------------------------------------------------------------
// The walker holds the 15 block pointers of one inode and translates logical
// block numbers through the direct slots and the single, double and triple
// indirect trees. Each indirect level costs one round trip: the walker sends
// a read request beat naming an indirect block and a word within it, and the
// word read back returns as a response beat on the request channel. Every
// request beat passes an input register and one decision stage into the
// result register, and one beat is accepted in every cycle while the result
// side keeps taking beats. The result register is the only stall point; when
// it is full and not taken, the decision stage holds and the request channel
// stops after one more beat. Loads, unused operation codes and read words
// that arrive while no walk is active give no result beat. A translate beat
// always drops a walk that is still in flight.
module inode_block_map_walker (
   input  logic clock,
   input  logic reset,
   ibmw_req_if.sink   req_bus,
   ibmw_rsp_if.source rsp_bus
);
   import ibmw_pkg::*;

   // Input register: the beat that the decision stage works on.
   logic                 st_valid_ff;
   logic [OP_W-1:0]      st_op_ff;
   logic [SLOT_W-1:0]    st_slot_ff;
   logic [PTR_W-1:0]     st_pv_ff;
   logic [LBLK_W-1:0]    st_lb_ff;

   // Block map and walk state.
   logic [PTR_W-1:0]     ptr_ff [NUM_SLOTS];
   logic                 walk_ff;
   logic                 walk_in;
   logic [LEVEL_W-1:0]   level_ff;
   logic [LEVEL_W-1:0]   level_in;
   logic [OFF_W-1:0]     offset_ff;
   logic [OFF_W-1:0]     offset_in;

   // Result register.
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [PTR_W-1:0]     rsp_addr_ff;
   logic [INDEX_W-1:0]   rsp_index_ff;

   // Decision stage outputs.
   logic                 advance;
   logic                 req_fire;
   logic                 has_result;
   logic                 slot_write;
   status_type           res_status;
   logic [PTR_W-1:0]     res_addr;
   logic [INDEX_W-1:0]   res_index;
   logic [PTR_W-1:0]     direct_ptr;
   logic [PTR_W-1:0]     tree_ptr;
   logic [OFF_W-1:0]     tree_offset;
   logic [LEVEL_W-1:0]   tree_level;
   logic [63:0]          lb_wide;

   // Pick the pointer word that the next read addresses: the offset, shifted
   // down by the levels still below it, taken modulo the pointers per block.
   function automatic logic [INDEX_W-1:0] word_of(input logic [OFF_W-1:0] off,
                                                  input logic [LEVEL_W-1:0] lev);
      logic [31:0] w;
      case (lev)
         2'd0:    w = 32'(off);
         2'd1:    w = 32'(off) >> PTR_BITS;
         default: w = 32'(off) >> (2 * PTR_BITS);
      endcase
      w = w & 32'(PTRS_PER_BLOCK - 1);
      return w[INDEX_W-1:0];
   endfunction

   // The stage moves on when the result register is free or being emptied.
   assign advance       = st_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !st_valid_ff || advance;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.block_addr = rsp_addr_ff;
   assign rsp_bus.word_index = rsp_index_ff;

   assign lb_wide    = 64'(st_lb_ff);
   assign direct_ptr = ptr_ff[st_lb_ff[SLOT_W-1:0]];

   // Choose the indirect tree for a translate: its root slot, the offset
   // inside its reach and the levels still to read after the first one.
   always_comb begin
      if (lb_wide < 64'(LIMIT_SINGLE)) begin
         tree_ptr    = ptr_ff[SLOT_SINGLE];
         tree_offset = OFF_W'(lb_wide - 64'(LIMIT_DIRECT));
         tree_level  = 2'd0;
      end else if (lb_wide < 64'(LIMIT_DOUBLE)) begin
         tree_ptr    = ptr_ff[SLOT_DOUBLE];
         tree_offset = OFF_W'(lb_wide - 64'(LIMIT_SINGLE));
         tree_level  = 2'd1;
      end else begin
         tree_ptr    = ptr_ff[SLOT_TRIPLE];
         tree_offset = OFF_W'(lb_wide - 64'(LIMIT_DOUBLE));
         tree_level  = 2'd2;
      end
   end

   // One level decision per beat.
   always_comb begin
      has_result = 1'b0;
      slot_write = 1'b0;
      res_status = STATUS_HOLE;
      res_addr   = '0;
      res_index  = '0;
      walk_in    = walk_ff;
      level_in   = level_ff;
      offset_in  = offset_ff;
      case (st_op_ff)
         OP_LOAD: begin
            slot_write = (32'(st_slot_ff) < 32'(NUM_SLOTS));
         end
         OP_TRANSLATE: begin
            has_result = 1'b1;
            walk_in    = 1'b0;
            if (lb_wide < 64'(LIMIT_DIRECT)) begin
               if (direct_ptr != '0) begin
                  res_status = STATUS_MAPPED;
                  res_addr   = direct_ptr;
               end
            end else if (lb_wide < 64'(LIMIT_TRIPLE)) begin
               // A zero root pointer is a hole; it closes the walk and leaves level and offset alone.
               if (tree_ptr != '0) begin
                  walk_in    = 1'b1;
                  level_in   = tree_level;
                  offset_in  = tree_offset;
                  res_status = STATUS_READ;
                  res_addr   = tree_ptr;
               end
            end else begin
               res_status = STATUS_RANGE;
            end
         end
         OP_RESPONSE: begin
            if (walk_ff) begin
               has_result = 1'b1;
               if (st_pv_ff == '0) begin
                  walk_in = 1'b0;
               end else if (level_ff == '0) begin
                  walk_in    = 1'b0;
                  res_status = STATUS_MAPPED;
                  res_addr   = st_pv_ff;
               end else begin
                  level_in   = level_ff - 2'd1;
                  res_status = STATUS_READ;
                  res_addr   = st_pv_ff;
               end
            end
         end
         default: begin
         end
      endcase
      if (res_status == STATUS_READ) begin
         res_index = word_of(offset_in, level_in);
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else if (req_fire) begin
         st_valid_ff <= 1'b1;
      end else if (advance) begin
         st_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         st_op_ff   <= req_bus.op;
         st_slot_ff <= req_bus.slot;
         st_pv_ff   <= req_bus.pointer_value;
         st_lb_ff   <= req_bus.logical_block;
      end
   end

   // Block map and walk state, updated as each beat leaves the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            ptr_ff[i] <= '0;
         end
         walk_ff   <= 1'b0;
         level_ff  <= '0;
         offset_ff <= '0;
      end else if (advance) begin
         if (slot_write) begin
            ptr_ff[st_slot_ff] <= st_pv_ff;
         end
         walk_ff   <= walk_in;
         level_ff  <= level_in;
         offset_ff <= offset_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && has_result) begin
         rsp_status_ff <= res_status;
         rsp_addr_ff   <= res_addr;
         rsp_index_ff  <= res_index;
      end
   end

   // A read request beat leaves a walk open; any final status closes it.
   assert property (@(posedge clock) disable iff (reset)
      (advance && has_result && res_status == STATUS_READ) |=> walk_ff)
      else $error("walk not open after a read request");

   assert property (@(posedge clock) disable iff (reset)
      (advance && has_result && res_status != STATUS_READ) |=> !walk_ff)
      else $error("walk still open after a final status");

   // An open walk never has more than two levels left below the pending read.
   assert property (@(posedge clock) disable iff (reset)
      walk_ff |-> (level_ff != 2'd3))
      else $error("walk level out of range");

   // The request side stalls only behind a full, untaken result register.
   assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (st_valid_ff && rsp_valid_ff && !rsp_bus.ready))
      else $error("request side stalled without cause");

endmodule
